>>> sv/moisture_sensor_averager_unit_defines.svh
// Assertion macros for the moisture sensor averager.
// Taken by `include in the RTL files that carry checks; no other dependencies.
`ifndef MOISTURE_SENSOR_AVERAGER_UNIT_DEFINES_SVH
`define MOISTURE_SENSOR_AVERAGER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MSA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSA_ASSERT(name, clk, rst, prop, msg)
`define MSA_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

>>> sv/msa_pkg.sv
// Shared types and constants of the moisture sensor averager.
// No dependencies.
package msa_pkg;

  localparam int DIV_W   = 48;
  localparam int DCNT_W  = $clog2(DIV_W);

  // register indexes on the config port
  localparam logic [1:0] REG_WAIT_TICKS    = 2'd0;
  localparam logic [1:0] REG_WATER_READING = 2'd1;
  localparam logic [1:0] REG_AIR_READING   = 2'd2;

  // map target span and fit coefficients, scaled by 10000
  localparam logic [15:0] MAP_LO   = 16'd1320;
  localparam logic [31:0] MAP_SPAN = 32'd1853;
  localparam logic signed [DIV_W-1:0] FIT_NUM0 = 48'sd1781470205000;
  localparam logic [31:0] FIT_K1   = 32'd528797270;
  localparam logic [31:0] FIT_K2   = 32'd4288140;
  localparam logic [31:0] FIT_K3   = 32'd9414;
  localparam logic signed [DIV_W-1:0] FIT_DEN0 = 48'sd10000;
  localparam logic [6:0]  PCT_MAX  = 7'd100;

  typedef struct packed {
    logic [15:0] sum;
    logic [11:0] water;
    logic [11:0] air;
  } calc_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] percent;
  } calc_st_t;

endpackage

>>> sv/msa_calc.sv
// Compute sequencer: average, calibration map and rational fit.
// One shared multiplier and one shared restoring divider. Uses msa_pkg and the defines header.
`include "moisture_sensor_averager_unit_defines.svh"

module msa_calc #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  msa_pkg::calc_req_t req,
  output msa_pkg::calc_st_t  st
);

  localparam int W = msa_pkg::DIV_W;

  // floor(sum / SAMPLE_COUNT) as (sum * AVG_RECIP) >> AVG_SH, exact for 16-bit sums
  localparam int AVG_SH = 16 + $clog2(SAMPLE_COUNT);
  localparam logic [31:0] AVG_RECIP = 32'(((1 << AVG_SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_AVG_MUL = 4'd1;
  localparam logic [3:0] S_MAP_MUL = 4'd2;
  localparam logic [3:0] S_MAP_LD  = 4'd3;
  localparam logic [3:0] S_MAP_DIV = 4'd4;
  localparam logic [3:0] S_MAP_FIN = 4'd5;
  localparam logic [3:0] S_SQ      = 4'd6;
  localparam logic [3:0] S_T1      = 4'd7;
  localparam logic [3:0] S_T2      = 4'd8;
  localparam logic [3:0] S_T3      = 4'd9;
  localparam logic [3:0] S_DEN     = 4'd10;
  localparam logic [3:0] S_FIT_LD  = 4'd11;
  localparam logic [3:0] S_FIT_DIV = 4'd12;
  localparam logic [3:0] S_FIT_FIN = 4'd13;

  logic [3:0]               state;
  logic [W-1:0]             dq;
  logic [W-1:0]             rem;
  logic [W-1:0]             dvs;
  logic [msa_pkg::DCNT_W-1:0] cnt;
  logic [W-1:0]             prod;
  logic [15:0]              m;
  logic [31:0]              sq;
  logic signed [W-1:0]      num;
  logic signed [W-1:0]      den;
  logic                     qneg;
  logic [6:0]               pct;
  logic                     done;

  logic [11:0]        avg;
  logic signed [12:0] diff;
  logic signed [12:0] span;
  logic [12:0]        diff_mag;
  logic [12:0]        span_mag;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [W:0]         rem_sh;
  logic [W:0]         rem_sub;
  logic               fits;
  logic               div_on;
  logic               div_ld;
  logic [W-1:0]       div_a;
  logic [W-1:0]       div_b;
  logic [W-1:0]       num_mag;
  logic [W-1:0]       den_mag;
  logic [15:0]        q16;

  // average is valid in prod during S_MAP_MUL
  assign avg      = prod[AVG_SH +: 12];
  assign diff     = signed'({1'b0, avg}) - signed'({1'b0, req.water});
  assign span     = signed'({1'b0, req.air}) - signed'({1'b0, req.water});
  assign diff_mag = diff[12] ? 13'(-diff) : 13'(diff);
  assign span_mag = span[12] ? 13'(-span) : 13'(span);
  assign num_mag  = num[W-1] ? W'(-num) : W'(num);
  assign den_mag  = den[W-1] ? W'(-den) : W'(den);
  assign q16      = dq[15:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_AVG_MUL: begin
        mul_a = 32'(req.sum);
        mul_b = AVG_RECIP;
      end
      S_MAP_MUL: begin
        mul_a = 32'(diff_mag);
        mul_b = msa_pkg::MAP_SPAN;
      end
      S_SQ: begin
        mul_a = 32'(m);
        mul_b = 32'(m);
      end
      S_T1: begin
        mul_a = 32'(m);
        mul_b = msa_pkg::FIT_K1;
      end
      S_T2: begin
        mul_a = 32'(m);
        mul_b = msa_pkg::FIT_K2;
      end
      S_T3: begin
        mul_a = sq;
        mul_b = msa_pkg::FIT_K3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider step and load
  assign div_on  = (state == S_MAP_DIV) || (state == S_FIT_DIV);
  assign rem_sh  = {rem, dq[W-1]};
  assign fits    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_comb begin
    div_ld = 1'b0;
    div_a  = '0;
    div_b  = '0;
    unique case (state)
      S_MAP_LD: begin
        div_ld = 1'b1;
        div_a  = prod;
        div_b  = W'(span_mag);
      end
      S_FIT_LD: begin
        div_ld = (den != '0);
        div_a  = num_mag;
        div_b  = den_mag;
      end
      default: begin
        div_ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_p[W-1:0];
    if (div_ld) begin
      dq  <= div_a;
      dvs <= div_b;
      rem <= '0;
      cnt <= msa_pkg::DCNT_W'(W - 1);
    end else if (div_on) begin
      rem <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
      dq  <= {dq[W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_AVG_MUL;
        end
        S_AVG_MUL: state <= S_MAP_MUL;
        S_MAP_MUL: begin
          // equal calibration points map straight to the low end
          if (req.water == req.air) begin
            m     <= msa_pkg::MAP_LO;
            state <= S_SQ;
          end else begin
            qneg  <= diff[12] ^ span[12];
            state <= S_MAP_LD;
          end
        end
        S_MAP_LD: state <= S_MAP_DIV;
        S_MAP_DIV: begin
          if (cnt == '0) state <= S_MAP_FIN;
        end
        S_MAP_FIN: begin
          m     <= 16'((qneg ? 16'(~q16 + 16'd1) : q16) + msa_pkg::MAP_LO);
          state <= S_SQ;
        end
        S_SQ: state <= S_T1;
        S_T1: begin
          sq    <= prod[31:0];
          state <= S_T2;
        end
        S_T2: begin
          num   <= msa_pkg::FIT_NUM0 - signed'(prod);
          state <= S_T3;
        end
        S_T3: begin
          den   <= msa_pkg::FIT_DEN0 - signed'(prod);
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= den + signed'(prod);
          state <= S_FIT_LD;
        end
        S_FIT_LD: begin
          if (den == '0) begin
            pct   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            qneg  <= num[W-1] ^ den[W-1];
            state <= S_FIT_DIV;
          end
        end
        S_FIT_DIV: begin
          if (cnt == '0) state <= S_FIT_FIN;
        end
        S_FIT_FIN: begin
          if (qneg) begin
            pct <= '0;
          end else if (dq > W'(msa_pkg::PCT_MAX)) begin
            pct <= msa_pkg::PCT_MAX;
          end else begin
            pct <= dq[6:0];
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign st.done    = done;
  assign st.percent = pct;

  `MSA_ASSERT(a_start_idle, clk, rst, start |-> state == S_IDLE, "start while sequencer busy")
  `MSA_ASSERT(a_done_pulse, clk, rst, done |=> !done, "done longer than one cycle")
  `MSA_ASSERT(a_div_nonzero, clk, rst, div_on |-> dvs != '0, "divider running on zero divisor")

endmodule

>>> sv/moisture_sensor_averager_unit.sv
// Top level of the moisture sensor averager: stream ports, phase control, sample sums.
// Uses msa_pkg, msa_calc and the defines header.
//
//  channel   | direction | transaction
//  s_*       | in        | one tick (tuser=0) or start request (tuser=1), ADC sample in tdata
//  m_*       | out       | one status word per input transaction
//  cfg_*     | in        | register write: index 0 wait_ticks, 1 water_reading, 2 air_reading
//
// A tick in the computing phase runs the shared multiply/divide sequencer: one
// reciprocal multiply for the average, two 48-step divides and the map and fit
// steps around them; s_tready stays low after that tick until the result word is
// loaded into the output. Equal calibration points skip the map divide, a zero fit divisor the fit one.
// A spare output word takes one status word while m_tready is low; a second waiting
// word holds off the input. Reset is synchronous; no clearing pass.
`include "moisture_sensor_averager_unit_defines.svh"

module moisture_sensor_averager_unit #(
  parameter int SAMPLE_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] adc_sample, [15:12] zero
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] power_on, [1] busy_rejected, [2] done_res,
                                 // [9:3] moisture_percent, [15:10] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_POWERUP = 2'd1;
  localparam logic [1:0] PH_MEASURE = 2'd2;
  localparam logic [1:0] PH_COMPUTE = 2'd3;

  logic [31:0]      wait_ticks;
  logic [11:0]      water_reading;
  logic [11:0]      air_reading;

  logic [1:0]       phase;
  logic [CNT_W-1:0] sample_count;
  logic [15:0]      sample_sum;
  logic [31:0]      ticks_since_sample;
  logic             power_level;
  logic [6:0]       percent_hold;
  logic             wait_calc;
  logic             emit_pend;
  logic             sk_valid;
  logic [15:0]      sk_data;

  logic [1:0]       phase_next;
  logic [CNT_W-1:0] sample_count_next;
  logic [15:0]      sample_sum_next;
  logic [31:0]      ticks_next;
  logic             power_next;
  logic             rejected;
  logic             start_calc;
  logic [31:0]      ticks_adv;
  logic             take;
  logic             s_acc;
  logic             out_free;
  logic [15:0]      status_word;

  msa_pkg::calc_req_t calc_req;
  msa_pkg::calc_st_t  calc_st;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !wait_calc && !emit_pend && !sk_valid;
  assign s_acc     = s_tvalid && s_tready;

  // saturating tick counter and sample decision for a measuring tick
  assign ticks_adv = (ticks_since_sample != '1) ? ticks_since_sample + 32'd1 : ticks_since_sample;
  assign take      = (sample_count < CNT_W'(SAMPLE_COUNT)) && (ticks_adv >= wait_ticks);

  always_comb begin
    phase_next        = phase;
    sample_count_next = sample_count;
    sample_sum_next   = sample_sum;
    ticks_next        = ticks_since_sample;
    power_next        = power_level;
    rejected          = 1'b0;
    start_calc        = 1'b0;
    if (s_tuser) begin
      if (phase == PH_IDLE) phase_next = PH_POWERUP;
      else rejected = 1'b1;
    end else begin
      unique case (phase)
        PH_IDLE: phase_next = PH_IDLE;
        PH_POWERUP: begin
          sample_sum_next   = '0;
          sample_count_next = '0;
          ticks_next        = '1;
          power_next        = 1'b1;
          phase_next        = PH_MEASURE;
        end
        PH_MEASURE: begin
          ticks_next = ticks_adv;
          if (take) begin
            ticks_next        = '0;
            sample_sum_next   = sample_sum + 16'(s_tdata[11:0]);
            sample_count_next = sample_count + 1'b1;
          end
          if (sample_count_next >= CNT_W'(SAMPLE_COUNT)) begin
            power_next = 1'b0;
            phase_next = PH_COMPUTE;
          end
        end
        PH_COMPUTE: start_calc = 1'b1;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  assign status_word = {6'd0, percent_hold, 1'b0, rejected, power_next};

  assign calc_req.sum   = sample_sum;
  assign calc_req.water = water_reading;
  assign calc_req.air   = air_reading;

  msa_calc #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (s_acc && start_calc),
    .req   (calc_req),
    .st    (calc_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks         <= 32'd100;
      water_reading      <= 12'd1320;
      air_reading        <= 12'd3173;
      phase              <= PH_IDLE;
      sample_count       <= '0;
      sample_sum         <= '0;
      ticks_since_sample <= '1;
      power_level        <= 1'b0;
      percent_hold       <= '0;
      wait_calc          <= 1'b0;
      emit_pend          <= 1'b0;
      sk_valid           <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          msa_pkg::REG_WAIT_TICKS:    wait_ticks    <= cfg_data;
          msa_pkg::REG_WATER_READING: water_reading <= cfg_data[11:0];
          msa_pkg::REG_AIR_READING:   air_reading   <= cfg_data[11:0];
          default: ;
        endcase
      end

      if (s_acc) begin
        phase              <= phase_next;
        sample_count       <= sample_count_next;
        sample_sum         <= sample_sum_next;
        ticks_since_sample <= ticks_next;
        power_level        <= power_next;
        if (start_calc) wait_calc <= 1'b1;
      end else if (calc_st.done) begin
        // compute finished: store result, report on the next free output slot
        percent_hold <= calc_st.percent;
        phase        <= PH_IDLE;
        wait_calc    <= 1'b0;
        emit_pend    <= 1'b1;
      end

      // output stage: main word plus one spare word
      if (s_acc && !start_calc) begin
        if (out_free) begin
          m_tvalid <= 1'b1;
          m_tdata  <= status_word;
        end else begin
          sk_valid <= 1'b1;
          sk_data  <= status_word;
        end
      end else if (sk_valid && m_tready) begin
        m_tdata  <= sk_data;
        sk_valid <= 1'b0;
      end else if (emit_pend && out_free) begin
        m_tvalid  <= 1'b1;
        m_tdata   <= {6'd0, percent_hold, 1'b1, 1'b0, power_level};
        emit_pend <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `MSA_ASSERT(a_no_accept_busy, clk, rst, wait_calc |-> !s_tready, "input taken during compute")
  `MSA_ASSERT(a_power_measure, clk, rst, power_level |-> phase == PH_MEASURE, "power on outside measuring")
  `MSA_ASSERT(a_done_expected, clk, rst, calc_st.done |-> wait_calc, "compute result without request")
  `MSA_ASSERT(a_spare_behind, clk, rst, sk_valid |-> m_tvalid, "spare word without main word")

endmodule
